// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define FDEC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port check failed");

// Next-cycle implication, disabled while rst is high.
`define FDEC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

// ===== rtl/fdec_pkg.sv =====
package fdec_pkg;

   // Wide integer held as a rotating line of words, least significant word first.
   localparam int WORD_BITS = 64;
   localparam int WORDS     = 18;
   localparam int WIDX_BITS = 5;

   localparam int Q_BITS     = 34;
   localparam int K_BITS     = 11;
   localparam int X_BITS     = 12;
   localparam int SHIFT_BITS = 11;
   localparam int PASS_BITS  = 9;

   localparam logic [Q_BITS-1:0] DIG_LOW  = 34'd1000000;
   localparam logic [Q_BITS-1:0] DIG_HIGH = 34'd10000000;

   localparam logic [2:0] CARRY_ZERO = 3'd0;

   localparam logic [1:0] CLASS_FINITE = 2'd0;
   localparam logic [1:0] CLASS_INF    = 2'd1;
   localparam logic [1:0] CLASS_NAN    = 2'd2;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_MUL_S,
      DP_MUL_D,
      DP_DIV
   } dp_op_type;

   typedef struct packed {
      dp_op_type              op;
      logic [WIDX_BITS-1:0]   word;
      logic                   shift_en;
      logic                   sel_t;
   } dp_cmd_type;

   typedef struct packed {
      logic borrow;
      logic nonzero;
   } dp_stat_type;

endpackage

// ===== rtl/fdec_lzc.sv =====
// Serial leading-zero count: one bit position per cycle.
module fdec_lzc (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [5:0]  count
);

   logic        busy_ff;
   logic [63:0] sh_ff;
   logic [5:0]  cnt_ff;

   assign done  = busy_ff && sh_ff[63];
   assign count = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff  <= value;
         cnt_ff <= 6'd0;
      end else if (busy_ff && !sh_ff[63]) begin
         sh_ff  <= {sh_ff[62:0], 1'b0};
         cnt_ff <= cnt_ff + 6'd1;
      end
   end

endmodule

// ===== rtl/fdec_bigword.sv =====
// Three wide integers (remainder S, trial difference T, divisor D) held as
// rotating word lines. Each command cycle processes the bottom word of each
// line and writes the result word at the top.
module fdec_bigword (
   input  logic                                  clock,
   input  fdec_pkg::dp_cmd_type                  cmd,
   input  logic [fdec_pkg::WORD_BITS-1:0]        mant,
   input  logic [fdec_pkg::SHIFT_BITS-1:0]       s_shift,
   input  logic [fdec_pkg::SHIFT_BITS-1:0]       d_shift,
   output fdec_pkg::dp_stat_type                 stat
);

   localparam int W = fdec_pkg::WORD_BITS;
   localparam int L = fdec_pkg::WORDS;

   logic [W-1:0] s_ff [L];
   logic [W-1:0] t_ff [L];
   logic [W-1:0] d_ff [L];
   logic         cin_ff;
   logic         borrow_ff;
   logic         nz_ff;
   logic [3:0]   mcarry_ff;

   logic                            first;
   logic                            cin;
   logic                            bin;
   logic [3:0]                      mc;
   logic [2*W-1:0]                  m_sh;
   logic [fdec_pkg::WIDX_BITS-1:0]  s_word;
   logic [fdec_pkg::WIDX_BITS-1:0]  d_word;
   logic [W-1:0]                    x;
   logic [W-1:0]                    xs;
   logic [W+3:0]                    prod;
   logic [W:0]                      diff;
   logic [W-1:0]                    s_new;
   logic [W-1:0]                    t_new;
   logic [W-1:0]                    d_new;

   always_comb begin
      first  = (cmd.word == '0);
      cin    = first ? 1'b0 : cin_ff;
      bin    = first ? 1'b0 : borrow_ff;
      mc     = first ? 4'd0 : mcarry_ff;
      m_sh   = {{W{1'b0}}, mant} << s_shift[5:0];
      s_word = s_shift[fdec_pkg::SHIFT_BITS-1:6];
      d_word = d_shift[fdec_pkg::SHIFT_BITS-1:6];
      x      = cmd.sel_t ? t_ff[0] : s_ff[0];
      xs     = cmd.shift_en ? {x[W-2:0], cin} : x;
      diff   = {1'b0, xs} - {1'b0, d_ff[0]} - {{W{1'b0}}, bin};
      prod   = ({4'd0, (cmd.op == fdec_pkg::DP_MUL_D) ? d_ff[0] : s_ff[0]} << 3)
             + ({4'd0, (cmd.op == fdec_pkg::DP_MUL_D) ? d_ff[0] : s_ff[0]} << 1)
             + {{W{1'b0}}, mc};
      s_new  = s_ff[0];
      t_new  = t_ff[0];
      d_new  = d_ff[0];
      case (cmd.op)
         fdec_pkg::DP_LOAD: begin
            s_new = '0;
            if (cmd.word == s_word) begin
               s_new = m_sh[W-1:0];
            end else if (cmd.word == s_word + 5'd1) begin
               s_new = m_sh[2*W-1:W];
            end
            d_new = (cmd.word == d_word) ? ({{(W-1){1'b0}}, 1'b1} << d_shift[5:0]) : '0;
            t_new = '0;
         end
         fdec_pkg::DP_MUL_S: begin
            s_new = prod[W-1:0];
         end
         fdec_pkg::DP_MUL_D: begin
            d_new = prod[W-1:0];
         end
         fdec_pkg::DP_DIV: begin
            s_new = xs;
            t_new = diff[W-1:0];
         end
         default: begin
            s_new = s_ff[0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op != fdec_pkg::DP_NOP) begin
         for (int i = 0; i < L - 1; i++) begin
            s_ff[i] <= s_ff[i+1];
            t_ff[i] <= t_ff[i+1];
            d_ff[i] <= d_ff[i+1];
         end
         s_ff[L-1] <= s_new;
         t_ff[L-1] <= t_new;
         d_ff[L-1] <= d_new;
         cin_ff    <= x[W-1];
         mcarry_ff <= prod[W+3:W];
         borrow_ff <= diff[W];
         nz_ff     <= (first ? 1'b0 : nz_ff) | (diff[W-1:0] != '0);
      end
   end

   assign stat.borrow  = borrow_ff;
   assign stat.nonzero = nz_ff;

endmodule

// ===== rtl/ieee_float_to_decimal_sci.sv =====
// Channel  | Direction | Contents
// req_     | in        | tdata[63:0] raw_bits (binary32 uses bits 31..0)
// rsp_     | out       | tdata: negative, digits, dec_exponent; tuser: value_class
// csr_     | in        | format_select (0 binary32, 1 binary64)
//
// Infinity, NaN and zero go from acceptance straight to the output state, which loads the
// result register once that register is free and then returns to idle for the next item.
// A finite value is normalized, gets a decimal exponent estimate, then runs A scaling attempts
// (A from 1 to 4), each a load pass, |6-k| multiply passes and the division passes, and is rounded;
// the word-serial multiply-by-ten passes over the 18-word integers dominate for large exponents.
// Reset is synchronous and active high; there is no clearing pass after reset.
// A waiting result never blocks the next item: only a second result waits.

module ieee_float_to_decimal_sci (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] raw_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] negative, [24:1] digits, [34:25] dec_exponent, zeros
   output logic [1:0]  rsp_tuser,   // [1:0] value_class
   input  logic        csr_wr_en,
   input  logic        csr_wr_data  // format_select
);

   localparam int QB = fdec_pkg::Q_BITS;
   localparam int KB = fdec_pkg::K_BITS;
   localparam int XB = fdec_pkg::X_BITS;
   localparam int SB = fdec_pkg::SHIFT_BITS;
   localparam int PB = fdec_pkg::PASS_BITS;
   localparam int WB = fdec_pkg::WIDX_BITS;

   localparam logic [WB-1:0] LAST_WORD = WB'(fdec_pkg::WORDS - 1);
   localparam logic [PB-1:0] LAST_PASS = PB'(fdec_pkg::Q_BITS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_KEST,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_DIVCHK,
      ST_ADJ,
      ST_ROUND,
      ST_OUT
   } state_type;

   state_type          state_ff;
   logic               fmt_ff;
   logic               sign_ff;
   logic [63:0]        m_ff;
   logic signed [XB-1:0] e_ff;
   logic signed [XB-1:0] x_ff;
   logic signed [KB-1:0] k_ff;
   logic [SB-1:0]      s_shift_ff;
   logic [SB-1:0]      d_shift_ff;
   logic [1:0]         iter_ff;
   logic [WB-1:0]      word_ff;
   logic [PB-1:0]      pass_ff;
   logic               mul_den_ff;
   logic               sel_ff;
   logic               up_ff;
   logic [QB-1:0]      q_ff;
   logic [1:0]         res_class_ff;
   logic [23:0]        res_digits_ff;
   logic [9:0]         res_exp_ff;
   logic               rsp_tvalid_ff;
   logic [39:0]        rsp_tdata_ff;
   logic [1:0]         rsp_tuser_ff;

   // Field split of the incoming item.
   logic                 in_sign;
   logic                 in_special;
   logic                 in_frac_nz;
   logic [63:0]          in_m;
   logic signed [XB-1:0] in_e;
   logic                 accept;
   logic                 lz_start;
   logic                 lz_done;
   logic [5:0]           lz_count;

   // Decimal exponent estimate.
   logic                 x_neg;
   logic [10:0]          ax;
   logic [28:0]          kprod;
   logic [28:0]          kbias;
   logic [KB-1:0]        kmag;
   logic signed [KB-1:0] k_est;
   logic signed [KB-1:0] p_val;

   logic                 q_hi;
   logic                 q_lo;
   logic [QB-1:0]        q_round;
   logic                 last_word;
   logic                 rsp_load;

   fdec_pkg::dp_cmd_type  cmd;
   fdec_pkg::dp_stat_type stat;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // The output register takes a new result when it is empty or being emptied.
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_tvalid_ff || rsp_tready);
   assign last_word = (word_ff == LAST_WORD);

   always_comb begin
      if (fmt_ff) begin
         in_sign    = req_tdata[63];
         in_special = &req_tdata[62:52];
         in_frac_nz = (req_tdata[51:0] != '0);
         in_m       = {11'd0, (req_tdata[62:52] != '0), req_tdata[51:0]};
         in_e       = (req_tdata[62:52] == '0) ? -12'sd1074
                    : $signed({1'b0, req_tdata[62:52]}) - 12'sd1075;
      end else begin
         in_sign    = req_tdata[31];
         in_special = &req_tdata[30:23];
         in_frac_nz = (req_tdata[22:0] != '0);
         in_m       = {40'd0, (req_tdata[30:23] != '0), req_tdata[22:0]};
         in_e       = (req_tdata[30:23] == '0) ? -12'sd149
                    : $signed({4'd0, req_tdata[30:23]}) - 12'sd150;
      end
   end

   assign lz_start = accept && !in_special && (in_m != '0);

   fdec_lzc u_lzc (
      .clock (clock),
      .reset (reset),
      .start (lz_start),
      .value (in_m),
      .done  (lz_done),
      .count (lz_count)
   );

   // The estimate is floor(x * log10(2)) with log10(2) taken as 78913 / 2^18.
   always_comb begin
      x_neg = x_ff[XB-1];
      ax    = x_neg ? 11'(-x_ff) : 11'(x_ff);
      kprod = {18'd0, ax} * 29'd78913;
      kbias = x_neg ? kprod + 29'd262143 : kprod;
      kmag  = kbias[28:18];
      k_est = x_neg ? -$signed(kmag) : $signed(kmag);
      p_val = 11'sd6 - k_ff;
   end

   always_comb begin
      q_hi    = (q_ff >= fdec_pkg::DIG_HIGH);
      q_lo    = (q_ff < fdec_pkg::DIG_LOW);
      q_round = q_ff + {{(QB-1){1'b0}}, up_ff};
   end

   always_comb begin
      cmd.word     = word_ff;
      cmd.shift_en = (pass_ff != '0);
      cmd.sel_t    = sel_ff;
      case (state_ff)
         ST_LOAD: cmd.op = fdec_pkg::DP_LOAD;
         ST_MUL:  cmd.op = mul_den_ff ? fdec_pkg::DP_MUL_D : fdec_pkg::DP_MUL_S;
         ST_DIV:  cmd.op = fdec_pkg::DP_DIV;
         default: cmd.op = fdec_pkg::DP_NOP;
      endcase
   end

   fdec_bigword u_big (
      .clock   (clock),
      .cmd     (cmd),
      .mant    (m_ff),
      .s_shift (s_shift_ff),
      .d_shift (d_shift_ff),
      .stat    (stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fmt_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            fmt_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  sign_ff       <= in_sign;
                  m_ff          <= in_m;
                  e_ff          <= in_e;
                  res_digits_ff <= '0;
                  res_exp_ff    <= '0;
                  if (!in_special) begin
                     res_class_ff <= fdec_pkg::CLASS_FINITE;
                  end else if (in_frac_nz) begin
                     res_class_ff <= fdec_pkg::CLASS_NAN;
                  end else begin
                     res_class_ff <= fdec_pkg::CLASS_INF;
                  end
                  if (in_special || (in_m == '0)) begin
                     state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_NORM;
                  end
               end
            end
            ST_NORM: begin
               if (lz_done) begin
                  x_ff     <= e_ff + 12'sd63 - $signed({6'd0, lz_count});
                  state_ff <= ST_KEST;
               end
            end
            ST_KEST: begin
               // Numerator m * 2^e split as an integer shift; the divisor
               // carries the extra 2^33 that aligns it with the top quotient bit.
               k_ff       <= k_est;
               s_shift_ff <= e_ff[XB-1] ? '0 : e_ff[SB-1:0];
               d_shift_ff <= (e_ff[XB-1] ? SB'(-e_ff) : '0) + 11'd33;
               iter_ff    <= 2'd0;
               word_ff    <= '0;
               q_ff       <= '0;
               sel_ff     <= 1'b0;
               pass_ff    <= '0;
               state_ff   <= ST_LOAD;
            end
            ST_LOAD: begin
               word_ff <= last_word ? '0 : word_ff + 5'd1;
               if (last_word) begin
                  mul_den_ff <= p_val[KB-1];
                  pass_ff    <= p_val[KB-1] ? PB'(-p_val) : PB'(p_val);
                  state_ff   <= (p_val == '0) ? ST_DIV : ST_MUL;
               end
            end
            ST_MUL: begin
               word_ff <= last_word ? '0 : word_ff + 5'd1;
               if (last_word) begin
                  pass_ff <= pass_ff - 9'd1;
                  if (pass_ff == 9'd1) begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               word_ff <= last_word ? '0 : word_ff + 5'd1;
               if (last_word) begin
                  state_ff <= ST_DIVCHK;
               end
            end
            ST_DIVCHK: begin
               // The last pass compares twice the remainder with the divisor.
               if (pass_ff == LAST_PASS) begin
                  up_ff    <= !stat.borrow && (stat.nonzero || q_ff[0]);
                  state_ff <= ST_ADJ;
               end else begin
                  q_ff     <= {q_ff[QB-2:0], !stat.borrow};
                  sel_ff   <= !stat.borrow;
                  pass_ff  <= pass_ff + 9'd1;
                  state_ff <= ST_DIV;
               end
            end
            ST_ADJ: begin
               if (q_hi) begin
                  k_ff <= k_ff + 11'sd1;
               end else if (q_lo) begin
                  k_ff <= k_ff - 11'sd1;
               end
               if ((!q_hi && !q_lo) || (iter_ff == 2'd3)) begin
                  state_ff <= ST_ROUND;
               end else begin
                  iter_ff  <= iter_ff + 2'd1;
                  word_ff  <= '0;
                  q_ff     <= '0;
                  sel_ff   <= 1'b0;
                  pass_ff  <= '0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_ROUND: begin
               // A round-up to ten million becomes one million at the next power.
               if (q_round >= fdec_pkg::DIG_HIGH) begin
                  res_digits_ff <= fdec_pkg::DIG_LOW[23:0];
                  res_exp_ff    <= 10'(k_ff + 11'sd1);
               end else begin
                  res_digits_ff <= q_round[23:0];
                  res_exp_ff    <= k_ff[9:0];
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_load) begin
                  rsp_tdata_ff <= {5'd0, res_exp_ff, res_digits_ff, sign_ff};
                  rsp_tuser_ff <= res_class_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/fdec_checker.sv =====
`include "assert_macros.svh"

module fdec_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   `FDEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `FDEC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)
   `FDEC_ASSERT_IMP(a_special_zero, clock, reset, rsp_tvalid && (rsp_tuser != fdec_pkg::CLASS_FINITE), rsp_tdata[34:1] == '0)
   `FDEC_ASSERT_IMP(a_digits_range, clock, reset, rsp_tvalid && (rsp_tdata[24:1] != '0), (rsp_tdata[24:1] >= 24'd1000000) && (rsp_tdata[24:1] <= 24'd9999999))
   `FDEC_ASSERT_IMP(a_zero_exp, clock, reset, rsp_tvalid && (rsp_tdata[24:1] == '0), rsp_tdata[34:25] == '0)

endmodule

bind ieee_float_to_decimal_sci fdec_checker u_fdec_checker (.*);
